FILE: rtl/core/bmts_pkg.sv
// Shared constants and controller/datapath interface types for the bigram sampler.
// No dependencies.
package bmts_pkg;
	localparam int SYMBOLS     = 256;
	localparam int COUNT_BITS  = 32;
	localparam int SYM_BITS    = 8;
	localparam int FUNC_BITS   = 2;
	localparam int RND_BITS    = 32;
	localparam int ROW_BITS    = 40;
	localparam int GRAND_BITS  = 48;
	localparam int PAIR_DEPTH  = SYMBOLS * SYMBOLS;
	localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
	localparam int ROW_AW      = $clog2(SYMBOLS);
	localparam int DIV_CW      = $clog2(RND_BITS);
	localparam int IN_BITS     = SYM_BITS + RND_BITS;
	localparam int OUT_BITS    = 16;

	localparam logic [SYM_BITS-1:0] DEFAULT_SYMBOL = 8'h65;

	localparam logic [FUNC_BITS-1:0] FUNC_PRIME   = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_OBSERVE = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_GEN_START = 2'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_GEN_NEXT  = 2'd3;

	typedef struct packed {
		logic clr;
		logic take;
		logic obs_upd;
		logic gen_sel;
		logic div_step;
		logic scan;
		logic put;
	} bmts_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic gen_empty;
		logic div_done;
		logic scan_done;
		logic out_free;
	} bmts_sts_t;
endpackage

FILE: rtl/core/bigram_markov_text_sampler.sv
// Top level of the bigram sampler: controller plus datapath.
// Depends on bmts_pkg, bmts_ctrl and bmts_dp.
//
// Input stream (s_*): tuser carries func (prime, observe, generate first,
// generate next); tdata carries symbol_in and random_value. Output stream
// (m_*) carries one transaction for each generate item: symbol_out,
// used_fallback and profile_empty.
// Prime is handled on acceptance; observe goes through acceptance, read, then
// update of count, row total and grand total. A generate item goes through
// acceptance and a row-total lookup, a 32-step serial modulo, a cumulative
// scan over up to 256 count words or row totals, one memory read per cycle,
// and the output load; the scan dominates. On an empty table the modulo and
// scan are skipped. Items are handled one at a time.
// After reset the block sweeps the pair memory, one entry per cycle, with
// s_tready low. The result sits in an output register; while the receiver
// stalls, prime and observe transactions still flow, and a generate item holds
// s_tready low in its last cycle until the held result is taken.
module bigram_markov_text_sampler
	import bmts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_BITS-1:0]   s_tdata,  // symbol_in[7:0], random_value[39:8]
	input  logic [FUNC_BITS-1:0] s_tuser,  // func[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_BITS-1:0]  m_tdata   // symbol_out[7:0], used_fallback[8], profile_empty[9]
);
	bmts_cmd_t cmd;
	bmts_sts_t sts;

	bmts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_func(s_tuser),
		.in_ready(s_tready), .sts(sts), .cmd(cmd)
	);

	bmts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_func(s_tuser),
		.in_sym(s_tdata[SYM_BITS-1:0]), .in_rnd(s_tdata[IN_BITS-1:SYM_BITS]),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
	);
endmodule

FILE: rtl/core/bmts_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module bmts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/bmts_ctrl.sv
// Controller state machine of the bigram sampler.
// Depends on bmts_pkg for the command and status types.
module bmts_ctrl
	import bmts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [FUNC_BITS-1:0] in_func,
	output logic                 in_ready,
	input  bmts_sts_t            sts,
	output bmts_cmd_t            cmd
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_OBS_RD, ST_OBS_WR, ST_GEN_RD, ST_GEN_SEL,
		ST_DIV, ST_SCAN, ST_PUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.take     = (state_q == ST_IDLE) && in_valid;
		cmd.obs_upd  = (state_q == ST_OBS_WR);
		cmd.gen_sel  = (state_q == ST_GEN_SEL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.put      = (state_q == ST_PUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (in_func)
							FUNC_PRIME:   state_q <= ST_IDLE;
							FUNC_OBSERVE: state_q <= ST_OBS_RD;
							default:      state_q <= ST_GEN_RD;
						endcase
					end
				end
				ST_OBS_RD:  state_q <= ST_OBS_WR;
				ST_OBS_WR:  state_q <= ST_IDLE;
				ST_GEN_RD:  state_q <= ST_GEN_SEL;
				ST_GEN_SEL: state_q <= sts.gen_empty ? ST_PUT : ST_DIV;
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_done) state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/bmts_dp.sv
// Datapath of the bigram sampler: count memories, totals, serial modulo, cumulative scan.
// Depends on bmts_pkg and bmts_ram.
module bmts_dp
	import bmts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmts_cmd_t            cmd,
	output bmts_sts_t            sts,
	input  logic [FUNC_BITS-1:0] in_func,
	input  logic [SYM_BITS-1:0]  in_sym,
	input  logic [RND_BITS-1:0]  in_rnd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_BITS-1:0]  out_data
);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [ROW_BITS-1:0]   ROW_MAX   = {ROW_BITS{1'b1}};
	localparam logic [GRAND_BITS-1:0] GRAND_MAX = {GRAND_BITS{1'b1}};

	logic [PAIR_AW-1:0]    clr_cnt_q;
	logic                  clr_done_q;
	logic [FUNC_BITS-1:0]  func_q;
	logic [SYM_BITS-1:0]   sym_q, prev_q, last_q;
	logic [RND_BITS-1:0]   rnd_q;
	logic [GRAND_BITS-1:0] grand_q, divisor_q, rem_q, run_q;
	logic [DIV_CW-1:0]     div_cnt_q;
	logic                  mode_q;
	logic [SYM_BITS:0]     scan_idx_q;
	logic                  vld_s1;
	logic [SYM_BITS-1:0]   idx_s1;
	logic [SYM_BITS-1:0]   res_sym_q;
	logic                  res_fb_q, res_empty_q;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	logic                  pair_we, row_we;
	logic [PAIR_AW-1:0]    pair_waddr, pair_raddr, obs_addr;
	logic [ROW_AW-1:0]     row_waddr, row_raddr;
	logic [COUNT_BITS-1:0] pair_wdata, pair_rdata;
	logic [ROW_BITS-1:0]   row_wdata, row_rdata;
	logic                  sym_ok, prev_ok, obs_ok, next_ok, last_ok;
	logic [GRAND_BITS:0]   div_t, div_d;
	logic [GRAND_BITS-1:0] scan_data, scan_sum;
	logic                  scan_hit, scan_end;

	assign sym_ok  = ({1'b0, sym_q} < (SYM_BITS+1)'(SYMBOLS));
	assign prev_ok = ({1'b0, prev_q} < (SYM_BITS+1)'(SYMBOLS));
	assign last_ok = ({1'b0, last_q} < (SYM_BITS+1)'(SYMBOLS));
	assign obs_addr = PAIR_AW'(PAIR_AW'(prev_q) * PAIR_AW'(SYMBOLS) + PAIR_AW'(sym_q));
	assign obs_ok = sym_ok && prev_ok && (pair_rdata != COUNT_MAX)
		&& (row_rdata != ROW_MAX) && (grand_q != GRAND_MAX);

	always_comb begin
		pair_we    = 1'b0;
		row_we     = 1'b0;
		pair_waddr = obs_addr;
		row_waddr  = ROW_AW'(prev_q);
		pair_wdata = pair_rdata + COUNT_BITS'(1);
		row_wdata  = row_rdata + ROW_BITS'(1);
		if (cmd.clr) begin
			pair_we    = 1'b1;
			row_we     = 1'b1;
			pair_waddr = clr_cnt_q;
			row_waddr  = ROW_AW'(clr_cnt_q);
			pair_wdata = '0;
			row_wdata  = '0;
		end else if (cmd.obs_upd && obs_ok) begin
			pair_we = 1'b1;
			row_we  = 1'b1;
		end
	end

	always_comb begin
		if (cmd.scan) begin
			row_raddr  = ROW_AW'(scan_idx_q);
			pair_raddr = PAIR_AW'(PAIR_AW'(last_q) * PAIR_AW'(SYMBOLS)
				+ PAIR_AW'(scan_idx_q));
		end else if (cmd.gen_sel || cmd.div_step) begin
			row_raddr  = ROW_AW'(last_q);
			pair_raddr = obs_addr;
		end else begin
			row_raddr  = (func_q == FUNC_OBSERVE) ? ROW_AW'(prev_q) : ROW_AW'(last_q);
			pair_raddr = obs_addr;
		end
	end

	bmts_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
		.clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
		.raddr(pair_raddr), .rdata(pair_rdata)
	);

	bmts_ram #(.WIDTH(ROW_BITS), .DEPTH(SYMBOLS)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
		.raddr(row_raddr), .rdata(row_rdata)
	);

	assign next_ok = (func_q == FUNC_GEN_NEXT) && last_ok && (row_rdata != '0);

	assign div_t = {rem_q, rnd_q[RND_BITS-1]};
	assign div_d = div_t - {1'b0, divisor_q};

	assign scan_data = mode_q ? GRAND_BITS'(pair_rdata) : GRAND_BITS'(row_rdata);
	assign scan_sum  = run_q + scan_data;
	assign scan_hit  = vld_s1 && (rem_q < scan_sum);
	assign scan_end  = vld_s1 && (idx_s1 == SYM_BITS'(SYMBOLS - 1));

	always_comb begin
		sts.clr_done  = clr_done_q;
		sts.gen_empty = !next_ok && (grand_q == '0);
		sts.div_done  = (div_cnt_q == DIV_CW'(RND_BITS - 1));
		sts.scan_done = scan_hit || scan_end;
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			clr_done_q  <= 1'b0;
			grand_q     <= '0;
			prev_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + PAIR_AW'(1);
				if (clr_cnt_q == PAIR_AW'(PAIR_DEPTH - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.take && (in_func == FUNC_PRIME)
				&& ({1'b0, in_sym} < (SYM_BITS+1)'(SYMBOLS))) begin
				prev_q <= in_sym;
			end
			if (cmd.obs_upd && sym_ok) begin
				prev_q <= sym_q;
				if (obs_ok) grand_q <= grand_q + GRAND_BITS'(1);
			end
			if (cmd.gen_sel) begin
				vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1 <= (scan_idx_q < (SYM_BITS+1)'(SYMBOLS));
			end
			if (cmd.put) begin
				out_valid_q <= 1'b1;
				last_q      <= res_sym_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= in_func;
			sym_q  <= in_sym;
			rnd_q  <= in_rnd;
		end
		if (cmd.gen_sel) begin
			mode_q      <= next_ok;
			divisor_q   <= next_ok ? GRAND_BITS'(row_rdata) : grand_q;
			res_fb_q    <= (func_q == FUNC_GEN_NEXT) && !next_ok;
			res_empty_q <= !next_ok && (grand_q == '0);
			res_sym_q   <= DEFAULT_SYMBOL;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			scan_idx_q  <= '0;
			run_q       <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= div_d[GRAND_BITS] ? div_t[GRAND_BITS-1:0] : div_d[GRAND_BITS-1:0];
			rnd_q     <= {rnd_q[RND_BITS-2:0], 1'b0};
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
		end
		if (cmd.scan) begin
			idx_s1     <= SYM_BITS'(scan_idx_q);
			if (scan_idx_q < (SYM_BITS+1)'(SYMBOLS)) begin
				scan_idx_q <= scan_idx_q + (SYM_BITS+1)'(1);
			end
			if (vld_s1) run_q <= scan_sum;
			if (scan_hit) begin
				res_sym_q <= idx_s1;
			end else if (scan_end) begin
				res_sym_q   <= DEFAULT_SYMBOL;
				res_fb_q    <= 1'b0;
				res_empty_q <= 1'b0;
			end
		end
		if (cmd.put) begin
			out_data_q <= OUT_BITS'({res_empty_q, res_fb_q, res_sym_q});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

FILE: tb/tb_bigram_markov_text_sampler.sv
`timescale 1ns / 100ps
// Self-checking bench for bigram_markov_text_sampler: drives prime, observe and generate
// transactions, predicts each generated byte from a local copy of the count table.
// Depends on bmts_pkg and the bigram_markov_text_sampler RTL.
module tb_bigram_markov_text_sampler;
	import bmts_pkg::*;

	typedef struct packed {
		logic [SYM_BITS-1:0] sym;
		logic                fallback;
		logic                empty;
	} gen_result_t;

	typedef struct {
		logic [FUNC_BITS-1:0] func;
		logic [SYM_BITS-1:0]  sym;
		logic [RND_BITS-1:0]  rnd;
		bit                   typed;
		gen_result_t          res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_BITS-1:0]   s_tdata = '0;
	logic [FUNC_BITS-1:0] s_tuser = FUNC_PRIME;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_BITS-1:0]  m_tdata;

	bigram_markov_text_sampler dut (.*);

	always #5 clk = ~clk;

	longint unsigned pair_cnt [SYMBOLS*SYMBOLS];
	longint unsigned row_sum [SYMBOLS];
	longint unsigned total_sum;
	logic [SYM_BITS-1:0] prev_sym, last_gen;
	gen_result_t expected_q[$];
	int errors, accepted_in, accepted_out, fallbacks, empties;
	int idle_cycles;
	bit stim_done, hold_off;
	stim_row_t rows[$];

	function automatic gen_result_t pick_from_rows(longint unsigned rnd);
		gen_result_t r;
		longint unsigned x, run;
		r = '{DEFAULT_SYMBOL, 1'b0, 1'b0};
		if (total_sum == 0) begin
			r.empty = 1'b1;
			return r;
		end
		x = rnd % total_sum;
		run = 0;
		for (int i = 0; i < SYMBOLS; i++) begin
			run += row_sum[i];
			if (x < run) begin
				r.sym = SYM_BITS'(i);
				return r;
			end
		end
		return r;
	endfunction

	function automatic void predict_item(logic [FUNC_BITS-1:0] f, logic [SYM_BITS-1:0] s,
			logic [RND_BITS-1:0] rnd);
		gen_result_t r;
		longint unsigned x, run;
		int idx;
		case (f)
			FUNC_PRIME: prev_sym = s;
			FUNC_OBSERVE: begin
				idx = prev_sym * SYMBOLS + s;
				if (pair_cnt[idx] < 64'hFFFF_FFFF && row_sum[prev_sym] < (64'd1 << 40) - 1 &&
						total_sum < (64'd1 << 48) - 1) begin
					pair_cnt[idx]++;
					row_sum[prev_sym]++;
					total_sum++;
				end
				prev_sym = s;
			end
			FUNC_GEN_START: r = pick_from_rows(rnd);
			default: begin
				if (row_sum[last_gen] == 0) begin
					r = pick_from_rows(rnd);
					r.fallback = 1'b1;
				end else begin
					r = '{DEFAULT_SYMBOL, 1'b0, 1'b0};
					x = rnd % row_sum[last_gen];
					run = 0;
					for (int j = 0; j < SYMBOLS; j++) begin
						run += pair_cnt[last_gen * SYMBOLS + j];
						if (x < run) begin
							r.sym = SYM_BITS'(j);
							break;
						end
					end
				end
			end
		endcase
		if (f == FUNC_GEN_START || f == FUNC_GEN_NEXT) begin
			last_gen = r.sym;
			expected_q.push_back(r);
		end
	endfunction

	task automatic send_item(logic [FUNC_BITS-1:0] f, logic [SYM_BITS-1:0] s,
			logic [RND_BITS-1:0] rnd);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {rnd, s};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(f, s, rnd);
		accepted_in++;
	endtask

	function automatic stim_row_t mk(logic [FUNC_BITS-1:0] f, logic [SYM_BITS-1:0] s,
			logic [RND_BITS-1:0] rnd, bit typed = 0,
			gen_result_t res = '{DEFAULT_SYMBOL, 1'b0, 1'b0});
		stim_row_t r;
		r.func = f;
		r.sym = s;
		r.rnd = rnd;
		r.typed = typed;
		r.res = res;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!hold_off && m_tready && $urandom_range(0, 4) == 0)
			m_tready <= 1'b0;
		else if (!hold_off && !m_tready)
			m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
		else if (hold_off)
			m_tready <= 1'b0;
	end

	always @(posedge clk) begin
		gen_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[8], m_tdata[9]};
			accepted_out++;
			if (expected_q.size() == 0) begin
				$error("unexpected result symbol_out=%0h", got.sym);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.sym !== want.sym) begin
					$error("symbol_out: expected %0h, actual %0h", want.sym, got.sym);
					errors++;
				end
				if (got.fallback !== want.fallback) begin
					$error("used_fallback: expected %0b, actual %0b", want.fallback, got.fallback);
					errors++;
				end
				if (got.empty !== want.empty) begin
					$error("profile_empty: expected %0b, actual %0b", want.empty, got.empty);
					errors++;
				end
				fallbacks += want.fallback;
				empties += want.empty;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("bigram_markov_text_sampler test failed");
			$finish;
		end
	end

	initial begin
		hold_off <= 1'b0;
		wait (accepted_in >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		logic [SYM_BITS-1:0] s;
		int n;
		total_sum = 0;
		prev_sym = '0;
		last_gen = '0;
		foreach (pair_cnt[i])
			pair_cnt[i] = 0;
		foreach (row_sum[i])
			row_sum[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(mk(FUNC_GEN_START, 8'h00, 32'hFFFF_FFFF, 1, '{8'h65, 1'b0, 1'b1}));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'h0, 1, '{8'h65, 1'b1, 1'b1}));
		rows.push_back(mk(FUNC_PRIME, 8'hFF, 32'hFFFF_FFFF));
		rows.push_back(mk(FUNC_OBSERVE, 8'h00, 32'h0));
		rows.push_back(mk(FUNC_GEN_START, 8'h00, 32'h0, 1, '{8'hFF, 1'b0, 1'b0}));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'hFFFF_FFFF, 1, '{8'h00, 1'b0, 1'b0}));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'h1234_5678, 1, '{8'hFF, 1'b1, 1'b0}));
		rows.push_back(mk(FUNC_OBSERVE, 8'hFF, 32'hAAAA_5555));
		rows.push_back(mk(FUNC_OBSERVE, 8'h80, 32'h5555_AAAA));
		rows.push_back(mk(FUNC_OBSERVE, 8'h7F, 32'h0));
		rows.push_back(mk(FUNC_OBSERVE, 8'hFF, 32'h0));
		rows.push_back(mk(FUNC_GEN_START, 8'h00, 32'hFFFF_FFFF));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'h8000_0000));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'h7FFF_FFFF));
		rows.push_back(mk(FUNC_GEN_NEXT, 8'h00, 32'h3));
		foreach (rows[i]) begin
			send_item(rows[i].func, rows[i].sym, rows[i].rnd);
			if (rows[i].typed && expected_q[$] !== rows[i].res) begin
				$error("directed row %0d: expected %p, predictor %p", i, rows[i].res,
					expected_q[$]);
				errors++;
			end
		end

		while (accepted_in < 1200) begin
			n = $urandom_range(0, 9);
			if (n < 6) begin
				send_item(FUNC_PRIME, 8'($urandom_range(0, 15)), $urandom);
				repeat ($urandom_range(3, 25)) begin
					s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
					send_item(FUNC_OBSERVE, s, $urandom);
				end
				send_item(FUNC_GEN_START, 8'($urandom), $urandom);
				repeat ($urandom_range(1, 8))
					send_item(FUNC_GEN_NEXT, 8'($urandom), $urandom);
			end else begin
				send_item(2'($urandom), 8'($urandom), $urandom);
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		$display("covered %0d input and %0d output transactions", accepted_in, accepted_out);
		$display("fallback draws %0d, empty-table draws %0d, table total %0d", fallbacks,
			empties, total_sum);
		if (errors == 0 && expected_q.size() == 0)
			$display("bigram_markov_text_sampler test passed");
		else
			$display("bigram_markov_text_sampler test failed");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/bmts_pkg.sv
rtl/core/bmts_ram.sv
rtl/core/bmts_ctrl.sv
rtl/core/bmts_dp.sv
rtl/core/bigram_markov_text_sampler.sv
tb/tb_bigram_markov_text_sampler.sv
